// File: src/spring_rk4_integrator_assert.svh
// Assertion macros for the spring follower.
// Included by the datapath; no other dependency.
`ifndef SPRING_RK4_INTEGRATOR_ASSERT_SVH
`define SPRING_RK4_INTEGRATOR_ASSERT_SVH

// clocked check, masked while reset is low
`define SRK4_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define SRK4_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/srk4_pkg.sv
// Shared types, command codes and constants for the spring follower.
// No dependencies; every module imports it.
package srk4_pkg;

  localparam int SRK4_FRAC_BITS  = 16;
  localparam int SRK4_DT_CAP     = 64000;
  localparam int SRK4_HMIN       = 100;
  localparam int SRK4_QA_LIMIT   = 1100;
  localparam int SRK4_MK_FACTOR  = 15625;
  localparam int SRK4_K4M        = 4000000;
  localparam int SRK4_DIV_HALF   = 2000000;
  localparam int SRK4_DIV_FULL   = 1000000;
  localparam int SRK4_DIV_SIXTH  = 6000000;

  localparam logic [2:0] REG_STIFFNESS = 3'd0;
  localparam logic [2:0] REG_DAMPING   = 3'd1;
  localparam logic [2:0] REG_MASS      = 3'd2;
  localparam logic [2:0] REG_TARGET    = 3'd3;
  localparam logic [2:0] REG_THRESHOLD = 3'd4;

  typedef struct packed {
    logic        func;
    logic [19:0] dt_us;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic               at_rest;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_HMAX_CAP, OP_SAVE, OP_DIV_STIFF, OP_SQRT, OP_HMAX_WB,
    OP_SUB_INIT, OP_FK, OP_FC, OP_DIV_ACC, OP_ACC_WB, OP_ACCUM, OP_DIV_SCALE,
    OP_SCALE_WB, OP_SUB_END, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {MS_KD, MS_CV, MS_SH, MS_MK, MS_QA, MS_RA} mul_sel_t;

  // scale targets: x2..x4 from v, v2..v4 from a, then final position and velocity
  typedef enum logic [1:0] {SC_X, SC_V, SC_PX, SC_PV} scale_sel_t;

  typedef enum logic [1:0] {D_HALF, D_FULL, D_SIXTH} dsel_t;

  typedef struct packed {
    op_t        op;
    logic       mul_en;
    mul_sel_t   mul_sel;
    scale_sel_t sc_sel;
    dsel_t      dsel;
    logic       dbl;
  } cmd_t;

  typedef struct packed {
    logic func;
    logic stiff_zero;
    logic qa_big;
    logic rem_zero;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_HM_CHK, S_HM_DIVA, S_HM_WAITA, S_HM_QA, S_HM_RA, S_HM_DIVB,
    S_HM_WAITB, S_HM_SQRT, S_HM_WAITS, S_HM_WB, S_SUB_CHK, S_ACC_KD, S_ACC_FK,
    S_ACC_FC, S_ACC_DIV, S_ACC_WAIT, S_ACC_WB, S_ACCUM, S_SC_MUL, S_SC_DIV,
    S_SC_WAIT, S_SC_WB, S_SUB_END, S_EMIT
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// File: src/spring_rk4_integrator.sv
// Top level of the damped spring follower (RK4, signed fixed point).
// Depends on srk4_pkg, srk4_ctrl and srk4_dp.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data: one word per tick. func = 1
//    zeroes position and velocity; func = 0 advances by dt_us microseconds
//    (capped at 64000) in RK4 substeps of at most the computed length.
//  - Output channel out_valid/out_ready/out_data: one word per input word,
//    carrying position, velocity and the at-rest flag.
//  - cfg_we/cfg_index/cfg_data write stiffness, damping, mass, target and
//    the rest threshold; write only while no word is in progress.
// Flow: a clear goes from idle through the emit state to the output register. A
//  tick first computes the substep length, then runs each substep (twelve
//  divisions on the shared divider plus multiplier steps), for up to 640
//  substeps. One word is worked on at a time; in_ready is high when idle.
// A finished word sits in the output register; the next input word is taken
//  while it waits, and a new result waits for out_ready before it is loaded.
// Reset (rst_n low, synchronous) zeroes position and velocity, restores the
//  default registers and drops out_valid.
module spring_rk4_integrator import srk4_pkg::*; #(
  parameter int FRAC_BITS = SRK4_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  cmd_t    cmd;
  status_t st;

  srk4_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  srk4_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

// File: src/srk4_div.sv
// Iterative unsigned divider, 64-bit dividend by 32-bit divisor.
// Four quotient bits per cycle. Uses srk4_pkg only by convention.
module srk4_div import srk4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);
  localparam int STEPS = 4;
  localparam int ITERS = 64 / STEPS;
  localparam int CW    = $clog2(ITERS);

  logic          busy_r, busy_nxt, done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [63:0]   q_r, q_nxt;
  logic [32:0]   r_r, r_nxt;
  logic [31:0]   d_r;

  always_comb begin
    logic [63:0] q;
    logic [32:0] r;
    q = q_r;
    r = r_r;
    for (int i = 0; i < STEPS; i++) begin
      r = {r[31:0], q[63]};
      q = {q[62:0], 1'b0};
      if (r >= {1'b0, d_r}) begin
        r    = r - {1'b0, d_r};
        q[0] = 1'b1;
      end
    end
    q_nxt    = q;
    r_nxt    = r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(ITERS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (busy_r) begin
      q_r <= q_nxt;
      r_r <= r_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[31:0];
endmodule

// File: src/srk4_sqrt.sv
// Bit-serial integer square root of a 36-bit value, one root bit per cycle.
// Uses srk4_pkg only by convention.
module srk4_sqrt import srk4_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [35:0] val,
  output logic        done,
  output logic [17:0] root
);
  localparam int ITERS = 18;
  localparam int CW    = $clog2(ITERS);

  logic          busy_r, done_r;
  logic [CW-1:0] cnt_r;
  logic [35:0]   v_r;
  logic [20:0]   r_r, r_nxt;
  logic [17:0]   root_r, root_nxt;

  always_comb begin
    logic [20:0] r;
    logic [20:0] trial;
    r     = {r_r[18:0], v_r[35:34]};
    trial = {1'b0, root_r, 2'b01};
    if (r >= trial) begin
      r_nxt    = r - trial;
      root_nxt = {root_r[16:0], 1'b1};
    end else begin
      r_nxt    = r;
      root_nxt = {root_r[16:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= val;
      r_r    <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[33:0], 2'b00};
      r_r    <= r_nxt;
      root_r <= root_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// File: src/srk4_ctrl.sv
// Controller: sequences substep length, RK4 stages and result hand-off.
// Depends on srk4_pkg; drives the datapath through cmd_t, reads status_t.
module srk4_ctrl import srk4_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);
  state_t     state_r, state_nxt;
  logic [1:0] stage_r, stage_nxt;
  scale_sel_t sc_r, sc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= '0;
      sc_r    <= SC_X;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      sc_r    <= sc_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    stage_nxt   = stage_r;
    sc_nxt      = sc_r;
    in_ready    = 1'b0;
    cmd.op      = OP_NONE;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = MS_KD;
    cmd.sc_sel  = sc_r;
    cmd.dbl     = (stage_r == 2'd1) || (stage_r == 2'd2);
    unique case (stage_r)
      2'd0, 2'd1: cmd.dsel = D_HALF;
      2'd2:       cmd.dsel = D_FULL;
      default:    cmd.dsel = D_SIXTH;
    endcase

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_START;
          state_nxt = st.func ? S_EMIT : S_HM_CHK;
        end
      end
      S_HM_CHK: begin
        if (st.stiff_zero) begin
          cmd.op    = OP_HMAX_CAP;
          state_nxt = S_SUB_CHK;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_MK;
          state_nxt   = S_HM_DIVA;
        end
      end
      S_HM_DIVA: begin
        cmd.op    = OP_DIV_STIFF;
        state_nxt = S_HM_WAITA;
      end
      S_HM_WAITA: if (st.div_done) state_nxt = S_HM_QA;
      S_HM_QA: begin
        if (st.qa_big) begin
          cmd.op    = OP_HMAX_CAP;
          state_nxt = S_SUB_CHK;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = MS_QA;
          state_nxt   = S_HM_RA;
        end
      end
      S_HM_RA: begin
        // keep the whole-part product while the fraction product is formed
        cmd.op      = OP_SAVE;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_RA;
        state_nxt   = S_HM_DIVB;
      end
      S_HM_DIVB: begin
        cmd.op    = OP_DIV_STIFF;
        state_nxt = S_HM_WAITB;
      end
      S_HM_WAITB: if (st.div_done) state_nxt = S_HM_SQRT;
      S_HM_SQRT: begin
        cmd.op    = OP_SQRT;
        state_nxt = S_HM_WAITS;
      end
      S_HM_WAITS: if (st.sqrt_done) state_nxt = S_HM_WB;
      S_HM_WB: begin
        cmd.op    = OP_HMAX_WB;
        state_nxt = S_SUB_CHK;
      end
      S_SUB_CHK: begin
        if (st.rem_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.op    = OP_SUB_INIT;
          stage_nxt = 2'd0;
          state_nxt = S_ACC_KD;
        end
      end
      S_ACC_KD: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_KD;
        state_nxt   = S_ACC_FK;
      end
      S_ACC_FK: begin
        cmd.op      = OP_FK;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_CV;
        state_nxt   = S_ACC_FC;
      end
      S_ACC_FC: begin
        cmd.op    = OP_FC;
        state_nxt = S_ACC_DIV;
      end
      S_ACC_DIV: begin
        cmd.op    = OP_DIV_ACC;
        state_nxt = S_ACC_WAIT;
      end
      S_ACC_WAIT: if (st.div_done) state_nxt = S_ACC_WB;
      S_ACC_WB: begin
        cmd.op    = OP_ACC_WB;
        state_nxt = S_ACCUM;
      end
      S_ACCUM: begin
        cmd.op    = OP_ACCUM;
        sc_nxt    = (stage_r == 2'd3) ? SC_PX : SC_X;
        state_nxt = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SH;
        state_nxt   = S_SC_DIV;
      end
      S_SC_DIV: begin
        cmd.op    = OP_DIV_SCALE;
        state_nxt = S_SC_WAIT;
      end
      S_SC_WAIT: if (st.div_done) state_nxt = S_SC_WB;
      S_SC_WB: begin
        cmd.op = OP_SCALE_WB;
        unique case (sc_r)
          SC_X: begin
            sc_nxt    = SC_V;
            state_nxt = S_SC_MUL;
          end
          SC_V: begin
            stage_nxt = stage_r + 2'd1;
            state_nxt = S_ACC_KD;
          end
          SC_PX: begin
            sc_nxt    = SC_PV;
            state_nxt = S_SC_MUL;
          end
          SC_PV: state_nxt = S_SUB_END;
        endcase
      end
      S_SUB_END: begin
        cmd.op    = OP_SUB_END;
        state_nxt = S_SUB_CHK;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (st.out_free) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// File: src/srk4_dp.sv
// Datapath: configuration, state, shared multiplier, divider, square root
// and the output register. Depends on srk4_pkg, srk4_div, srk4_sqrt.
`include "spring_rk4_integrator_assert.svh"
module srk4_dp import srk4_pkg::*; #(
  parameter int FRAC_BITS = SRK4_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output status_t     st,
  input  in_word_t    in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_word_t   out_data
);
  localparam logic signed [63:0] F_LIM  = (64'sd1 <<< (63 - FRAC_BITS)) - 64'sd1;
  localparam logic signed [63:0] RND    = 64'sd1 <<< (FRAC_BITS - 1);

  logic [31:0]        stiff_r, damp_r, mass_r;
  logic signed [31:0] tgt_r;
  logic [30:0]        thr_r;

  logic signed [31:0] x_r, v_r, xs_r, vs_r, a_r;
  logic signed [35:0] sx_r, sv_r;
  logic [15:0]        rem_r, h_r, hmax_r;
  logic signed [63:0] p_r, t_r, fk_r, f_r;
  logic               sgn_r;
  logic               out_valid_r;
  out_word_t          out_data_r;

  logic signed [35:0] mul_a, sh_src;
  logic signed [32:0] mul_b;
  logic signed [68:0] mul_full;
  logic signed [31:0] d_sat;

  logic               div_start, div_done;
  logic [63:0]        div_dvd, div_quot;
  logic [31:0]        div_dvs, div_rem;
  logic               sqrt_done;
  logic [17:0]        sqrt_root;

  logic signed [63:0] p_rnd, f_raw, f_cl, f_abs, p_abs, q_sgn;
  logic signed [31:0] q_sat, base, sc_res;
  logic [31:0]        dconst;
  logic signed [33:0] disp, disp_abs, spd_abs;
  logic               rest;
  logic [15:0]        dt_cl;

  srk4_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  srk4_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == OP_SQRT),
    .val   (36'(t_r + $signed(div_quot))),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  always_comb begin
    d_sat = sat32(64'(xs_r) - 64'(tgt_r));
    unique case (cmd.sc_sel)
      SC_X:  sh_src = 36'(vs_r);
      SC_V:  sh_src = 36'(a_r);
      SC_PX: sh_src = sx_r;
      SC_PV: sh_src = sv_r;
    endcase
    unique case (cmd.mul_sel)
      MS_KD: begin
        mul_a = $signed({4'b0, stiff_r});
        mul_b = 33'(d_sat);
      end
      MS_CV: begin
        mul_a = $signed({4'b0, damp_r});
        mul_b = 33'(vs_r);
      end
      MS_SH: begin
        mul_a = sh_src;
        mul_b = $signed({17'b0, h_r});
      end
      MS_MK: begin
        mul_a = $signed({4'b0, mass_r});
        mul_b = 33'(SRK4_MK_FACTOR);
      end
      MS_QA: begin
        mul_a = $signed({25'b0, div_quot[10:0]});
        mul_b = 33'(SRK4_K4M);
      end
      default: begin
        mul_a = $signed({4'b0, div_rem});
        mul_b = 33'(SRK4_K4M);
      end
    endcase
    mul_full = mul_a * mul_b;
  end

  always_comb begin
    p_rnd = (p_r + RND) >>> FRAC_BITS;
    f_raw = -fk_r - p_rnd;
    if (f_raw > F_LIM) begin
      f_cl = F_LIM;
    end else if (f_raw < -F_LIM) begin
      f_cl = -F_LIM;
    end else begin
      f_cl = f_raw;
    end
    f_abs = f_r[63] ? -f_r : f_r;
    p_abs = p_r[63] ? -p_r : p_r;
    unique case (cmd.dsel)
      D_HALF:  dconst = 32'(SRK4_DIV_HALF);
      D_FULL:  dconst = 32'(SRK4_DIV_FULL);
      default: dconst = 32'(SRK4_DIV_SIXTH);
    endcase

    div_start = 1'b0;
    div_dvd   = p_r;
    div_dvs   = stiff_r;
    priority case (cmd.op)
      OP_DIV_STIFF: div_start = 1'b1;
      OP_DIV_ACC: begin
        div_start = 1'b1;
        div_dvd   = f_abs <<< FRAC_BITS;
        div_dvs   = (mass_r == '0) ? 32'd1 : mass_r;
      end
      OP_DIV_SCALE: begin
        div_start = 1'b1;
        div_dvd   = p_abs + 64'(dconst >> 1);
        div_dvs   = dconst;
      end
      default: ;
    endcase

    q_sgn = sgn_r ? -$signed(div_quot) : $signed(div_quot);
    q_sat = sat32(q_sgn);
    base  = (cmd.sc_sel == SC_X || cmd.sc_sel == SC_PX) ? x_r : v_r;
    sc_res = sat32(64'(base) + 64'(q_sat));

    dt_cl = (in_data.dt_us > 20'(SRK4_DT_CAP)) ? 16'(SRK4_DT_CAP) : in_data.dt_us[15:0];

    disp     = 34'(x_r) - 34'(tgt_r);
    disp_abs = disp[33] ? -disp : disp;
    spd_abs  = v_r[31] ? -34'(v_r) : 34'(v_r);
    rest     = (disp_abs < $signed({3'b0, thr_r})) && (spd_abs < $signed({3'b0, thr_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= 32'd13107200;
      damp_r  <= 32'd1310720;
      mass_r  <= 32'd65536;
      tgt_r   <= '0;
      thr_r   <= 31'd655;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STIFFNESS: stiff_r <= cfg_data;
        REG_DAMPING:   damp_r  <= cfg_data;
        REG_MASS:      mass_r  <= cfg_data;
        REG_TARGET:    tgt_r   <= cfg_data;
        REG_THRESHOLD: thr_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= '0;
      v_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_START && in_data.func) begin
        x_r <= '0;
        v_r <= '0;
      end else if (cmd.op == OP_SCALE_WB && cmd.sc_sel == SC_PX) begin
        x_r <= sc_res;
      end else if (cmd.op == OP_SCALE_WB && cmd.sc_sel == SC_PV) begin
        v_r <= sc_res;
      end
      if (cmd.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) p_r <= mul_full[63:0];
    unique case (cmd.op)
      OP_START:    rem_r  <= dt_cl;
      OP_HMAX_CAP: hmax_r <= 16'(SRK4_DT_CAP);
      OP_SAVE:     t_r    <= p_r;
      OP_HMAX_WB: begin
        if (sqrt_root < 18'(SRK4_HMIN)) begin
          hmax_r <= 16'(SRK4_HMIN);
        end else if (sqrt_root > 18'(SRK4_DT_CAP)) begin
          hmax_r <= 16'(SRK4_DT_CAP);
        end else begin
          hmax_r <= sqrt_root[15:0];
        end
      end
      OP_SUB_INIT: begin
        h_r  <= (rem_r < hmax_r) ? rem_r : hmax_r;
        xs_r <= x_r;
        vs_r <= v_r;
        sx_r <= '0;
        sv_r <= '0;
      end
      OP_FK:        fk_r  <= p_rnd;
      OP_FC:        f_r   <= f_cl;
      OP_DIV_ACC:   sgn_r <= f_r[63];
      OP_DIV_SCALE: sgn_r <= p_r[63];
      OP_ACC_WB:    a_r   <= q_sat;
      OP_ACCUM: begin
        sx_r <= sx_r + (cmd.dbl ? (36'(vs_r) <<< 1) : 36'(vs_r));
        sv_r <= sv_r + (cmd.dbl ? (36'(a_r) <<< 1) : 36'(a_r));
      end
      OP_SCALE_WB: begin
        if (cmd.sc_sel == SC_X) xs_r <= sc_res;
        if (cmd.sc_sel == SC_V) vs_r <= sc_res;
      end
      OP_SUB_END: rem_r <= rem_r - h_r;
      OP_EMIT: begin
        out_data_r.position <= x_r;
        out_data_r.velocity <= v_r;
        out_data_r.at_rest  <= rest;
      end
      default: ;
    endcase
  end

  assign st.func       = in_data.func;
  assign st.stiff_zero = (stiff_r == '0);
  assign st.qa_big     = (div_quot >= 64'(SRK4_QA_LIMIT));
  assign st.rem_zero   = (rem_r == '0);
  assign st.div_done   = div_done;
  assign st.sqrt_done  = sqrt_done;
  assign st.out_free   = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  `SRK4_ASSERT(a_emit_free, clk, rst_n, (cmd.op == OP_EMIT) |-> (!out_valid_r || out_ready), "word emitted over an untaken result")
  `SRK4_ASSERT(a_sub_len, clk, rst_n, (cmd.op == OP_SUB_INIT) |=> (h_r != '0 && h_r <= hmax_r), "substep length out of range")
  `SRK4_ASSERT(a_rem_dec, clk, rst_n, (cmd.op == OP_SUB_END) |=> (rem_r == $past(rem_r - h_r)), "remaining time not reduced by the substep")
  `SRK4_ASSERT_ALWAYS(a_no_div_mix, clk, !(div_start && cmd.op == OP_SQRT), "divider and root started together")
endmodule
